// ----- sv/mvm_pkg.sv -----
// Shared types, sizes and helpers for the matrix-vector multiply core.
`default_nettype none

package mvm_pkg;

	// Storage limits
	localparam int MAX_ROWS  = 16;
	localparam int MAX_COLS  = 16;
	localparam int ROW_LIMIT = (MAX_ROWS < 16) ? MAX_ROWS : 16;
	localparam int COL_LIMIT = (MAX_COLS < 16) ? MAX_COLS : 16;
	localparam int VEC_DEPTH = 16;

	// Address widths into the weight memory
	localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int WADDR_W  = ROW_AW + COL_AW;
	localparam int W_DEPTH  = 1 << WADDR_W;

	// Field widths
	localparam int CFG_W    = 5;
	localparam int KIND_W   = 2;
	localparam int IDX_W    = 4;
	localparam int VAL_W    = 16;
	localparam int PROD_W   = 2 * VAL_W;
	localparam int ACC_W    = PROD_W + $clog2(COL_LIMIT + 1) + 1;
	localparam int FRAC_W   = 12;
	localparam int Q_W      = ACC_W - FRAC_W;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;
	localparam int M_USER_W = 2;

	localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(ROW_LIMIT);
	localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(COL_LIMIT);
	localparam logic [CFG_W-1:0] COUNT_MAX  = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_ELEM  = 2'd2
	} kind_t;

	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_MAC,
		ST_OUT
	} state_t;

	// Clamp a size register write to [1, limit]
	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] limit);
		logic [CFG_W-1:0] r;
		if (v == '0)
			r = CFG_W'(1);
		else if (v > limit)
			r = limit;
		else
			r = v;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/matrix_vector_multiply_core.sv -----
// Matrix-vector multiply core: weight memory, vector store and one shared MAC.
`default_nettype none

// Weights (signed Q4.12) live in a MAX_ROWS x MAX_COLS memory addressed by
// {row, col}; each entry has a valid flop cleared at reset, so an unwritten
// weight reads as zero and no clearing pass is needed. Input transfers carry a
// kind in s_tuser: write weight, add to weight (saturating) or vector element.
// Weight transfers outside the configured size are dropped. The element
// transfer with s_tlast set starts a run: one result per configured row,
// m_tlast on the final row. Each row walks its columns through a single
// multiplier and a 38-bit accumulator, then rounds to nearest (ties upward)
// into Q4.12 and clips, flagging saturation. If the element count of the run
// differs from cols_in_use every row returns zero with the size error flag.
// Timing: a weight add reads the memory, then writes the sum back. In a run
// the MAC issues one column per cycle through the memory read, multiply and
// accumulate registers; each row's result then waits in the output register
// until taken. s_tready stays low for the whole run. Configuration may only
// be written while the core is idle.

module matrix_vector_multiply_core (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration write port
	input  wire                                   cfg_we,
	input  wire                                   cfg_index,
	input  wire  [mvm_pkg::CFG_W-1:0]             cfg_data,
	// input stream
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [mvm_pkg::S_DATA_W-1:0]          s_tdata,  // row[3:0], col[7:4], value[23:8]
	input  wire  [mvm_pkg::KIND_W-1:0]            s_tuser,  // kind[1:0]
	input  wire                                   s_tlast,
	// result stream
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [mvm_pkg::M_DATA_W-1:0]          m_tdata,  // out_index[3:0], out_value[19:4], zero
	output logic [mvm_pkg::M_USER_W-1:0]          m_tuser,  // size_error[0], saturated[1]
	output logic                                  m_tlast
);

	// ---------------------------------------------------------------
	// Input field split
	// ---------------------------------------------------------------
	logic [mvm_pkg::IDX_W-1:0]  in_row;
	logic [mvm_pkg::IDX_W-1:0]  in_col;
	logic signed [mvm_pkg::VAL_W-1:0] in_value;
	mvm_pkg::kind_t             in_kind;
	logic                       in_xfer;
	logic                       in_fits;

	assign in_row   = s_tdata[3:0];
	assign in_col   = s_tdata[7:4];
	assign in_value = s_tdata[23:8];
	assign in_kind  = mvm_pkg::kind_t'(s_tuser);
	assign in_xfer  = s_tvalid && s_tready;

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	mvm_pkg::state_t state_q, state_d;

	logic [mvm_pkg::CFG_W-1:0]   rows_q, cols_q;
	logic [mvm_pkg::CFG_W-1:0]   count_q, count_inc;
	logic                        mismatch_q;
	logic [mvm_pkg::CFG_W-1:0]   row_q;
	logic [mvm_pkg::CFG_W-1:0]   issue_k_q;
	logic [mvm_pkg::WADDR_W-1:0] add_addr_q;
	logic signed [mvm_pkg::VAL_W-1:0] add_val_q;

	logic signed [mvm_pkg::VAL_W-1:0] vec_q [mvm_pkg::VEC_DEPTH];

	// weight memory, its valid flops and registered read port
	logic [mvm_pkg::VAL_W-1:0]   weight_mem [mvm_pkg::W_DEPTH];
	logic [mvm_pkg::W_DEPTH-1:0] wvld_q;
	logic [mvm_pkg::VAL_W-1:0]   rd_data_q;
	logic                        rd_vld_q;
	logic signed [mvm_pkg::VAL_W-1:0] w_eff;

	// MAC pipeline
	logic                              v_s1, v_s2;
	logic signed [mvm_pkg::VAL_W-1:0]  vdata_s1;
	logic signed [mvm_pkg::PROD_W-1:0] prod_s2;
	logic signed [mvm_pkg::ACC_W-1:0]  acc_q;

	// output register
	logic                              out_valid_q;
	logic [mvm_pkg::IDX_W-1:0]         out_index_q;
	logic [mvm_pkg::VAL_W-1:0]         out_value_q;
	logic                              out_err_q, out_sat_q, out_last_q;

	// ---------------------------------------------------------------
	// Sequencer controls
	// ---------------------------------------------------------------
	logic                        mem_re, mem_we;
	logic [mvm_pkg::WADDR_W-1:0] rd_addr, wr_addr;
	logic [mvm_pkg::VAL_W-1:0]   wr_data;
	logic                        issue, row_done, run_start, next_row;

	logic signed [mvm_pkg::VAL_W:0]   add_sum;
	logic signed [mvm_pkg::VAL_W-1:0] add_sat;
	logic signed [mvm_pkg::ACC_W-1:0] acc_bias;
	logic signed [mvm_pkg::Q_W-1:0]   q_full;
	logic [mvm_pkg::VAL_W-1:0]        q_clip;
	logic                             q_sat;

	localparam logic signed [mvm_pkg::Q_W-1:0] Q_MAX = mvm_pkg::Q_W'(32767);
	localparam logic signed [mvm_pkg::Q_W-1:0] Q_MIN = -mvm_pkg::Q_W'(32768);

	assign in_fits = ({1'b0, in_row} < rows_q) && ({1'b0, in_col} < cols_q);
	assign count_inc = (count_q == mvm_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
	assign w_eff = rd_vld_q ? rd_data_q : '0;

	// saturating weight add
	always_comb begin
		add_sum = {w_eff[mvm_pkg::VAL_W-1], w_eff} + {add_val_q[mvm_pkg::VAL_W-1], add_val_q};
		if (add_sum[mvm_pkg::VAL_W] != add_sum[mvm_pkg::VAL_W-1])
			add_sat = add_sum[mvm_pkg::VAL_W] ? {1'b1, {(mvm_pkg::VAL_W-1){1'b0}}}
				: {1'b0, {(mvm_pkg::VAL_W-1){1'b1}}};
		else
			add_sat = add_sum[mvm_pkg::VAL_W-1:0];
	end

	// round half up to Q4.12, then clip
	always_comb begin
		acc_bias = acc_q + mvm_pkg::ACC_W'(2048);
		q_full   = acc_bias[mvm_pkg::ACC_W-1:mvm_pkg::FRAC_W];
		q_sat    = 1'b0;
		if (q_full > Q_MAX) begin
			q_clip = 16'h7fff;
			q_sat  = 1'b1;
		end else if (q_full < Q_MIN) begin
			q_clip = 16'h8000;
			q_sat  = 1'b1;
		end else begin
			q_clip = q_full[mvm_pkg::VAL_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mvm_pkg::ST_IDLE: begin
				if (in_xfer) begin
					case (in_kind)
						mvm_pkg::KIND_ADD:  if (in_fits) state_d = mvm_pkg::ST_ADD;
						mvm_pkg::KIND_ELEM: if (s_tlast) state_d = mvm_pkg::ST_MAC;
						default:            state_d = mvm_pkg::ST_IDLE;
					endcase
				end
			end
			mvm_pkg::ST_ADD: state_d = mvm_pkg::ST_IDLE;
			mvm_pkg::ST_MAC: if (row_done) state_d = mvm_pkg::ST_OUT;
			mvm_pkg::ST_OUT: begin
				if (m_tready)
					state_d = out_last_q ? mvm_pkg::ST_IDLE : mvm_pkg::ST_MAC;
			end
			default: state_d = mvm_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		rd_addr   = {mvm_pkg::ROW_AW'(row_q), mvm_pkg::COL_AW'(issue_k_q)};
		wr_addr   = {mvm_pkg::ROW_AW'(in_row), mvm_pkg::COL_AW'(in_col)};
		wr_data   = in_value;
		issue     = 1'b0;
		row_done  = 1'b0;
		run_start = 1'b0;
		next_row  = 1'b0;
		case (state_q)
			mvm_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (in_xfer && in_fits) begin
					case (in_kind)
						mvm_pkg::KIND_WRITE: mem_we = 1'b1;
						mvm_pkg::KIND_ADD: begin
							mem_re  = 1'b1;
							rd_addr = wr_addr;
						end
						default: mem_we = 1'b0;
					endcase
				end
				run_start = in_xfer && (in_kind == mvm_pkg::KIND_ELEM) && s_tlast;
			end
			mvm_pkg::ST_ADD: begin
				mem_we  = 1'b1;
				wr_addr = add_addr_q;
				wr_data = add_sat;
			end
			mvm_pkg::ST_MAC: begin
				issue    = !mismatch_q && (issue_k_q < cols_q);
				mem_re   = issue;
				row_done = mismatch_q || ((issue_k_q == cols_q) && !v_s1 && !v_s2);
			end
			mvm_pkg::ST_OUT: next_row = m_tready && !out_last_q;
			default: s_tready = 1'b0;
		endcase
	end

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mvm_pkg::ST_IDLE;
			rows_q      <= mvm_pkg::ROWS_RESET;
			cols_q      <= mvm_pkg::COLS_RESET;
			count_q     <= '0;
			mismatch_q  <= 1'b0;
			row_q       <= '0;
			issue_k_q   <= '0;
			wvld_q      <= '0;
			rd_vld_q    <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (mvm_pkg::reg_idx_t'(cfg_index))
					mvm_pkg::REG_ROWS: rows_q <= mvm_pkg::clamp_size(cfg_data,
						mvm_pkg::ROWS_RESET);
					mvm_pkg::REG_COLS: cols_q <= mvm_pkg::clamp_size(cfg_data,
						mvm_pkg::COLS_RESET);
					default: rows_q <= rows_q;
				endcase
			end
			if (in_xfer && (in_kind == mvm_pkg::KIND_ELEM)) begin
				if (s_tlast) begin
					count_q    <= '0;
					mismatch_q <= (count_inc != cols_q);
				end else begin
					count_q <= count_inc;
				end
			end
			if (mem_we)
				wvld_q[wr_addr] <= 1'b1;
			if (mem_re)
				rd_vld_q <= wvld_q[rd_addr];
			if (run_start) begin
				row_q     <= '0;
				issue_k_q <= '0;
			end else if (next_row) begin
				row_q     <= row_q + 1'b1;
				issue_k_q <= '0;
			end else if (issue) begin
				issue_k_q <= issue_k_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (row_done)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Memory and datapath
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we)
			weight_mem[wr_addr] <= wr_data;
		if (mem_re)
			rd_data_q <= weight_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (in_kind == mvm_pkg::KIND_ELEM) && ({1'b0, in_col} <
				mvm_pkg::CFG_W'(mvm_pkg::COL_LIMIT)))
			vec_q[in_col] <= in_value;
		if (in_xfer) begin
			add_addr_q <= wr_addr;
			add_val_q  <= in_value;
		end
		if (issue)
			vdata_s1 <= vec_q[issue_k_q[mvm_pkg::IDX_W-1:0]];
		if (v_s1)
			prod_s2 <= w_eff * vdata_s1;
		if (run_start || next_row)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + mvm_pkg::ACC_W'(prod_s2);
		if (row_done) begin
			out_index_q <= row_q[mvm_pkg::IDX_W-1:0];
			out_value_q <= mismatch_q ? '0 : q_clip;
			out_err_q   <= mismatch_q;
			out_sat_q   <= !mismatch_q && q_sat;
			out_last_q  <= (row_q + 1'b1) == rows_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_value_q, out_index_q};
	assign m_tuser  = {out_sat_q, out_err_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire
